@@ sv/bam_pkg.sv @@
`timescale 1ns / 1ps

package bam_pkg;

    // Default number of bit slots in one frame.
    localparam int LEVEL_BITS_DEF = 8;

    // Fixed field widths.
    localparam int LEVEL_W     = 9;
    localparam int BASE_W      = 10;
    localparam int THRESH_W    = 8;
    localparam int FCOUNT_W    = 8;
    localparam int SLOT_OUT_W  = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_START_LEVEL    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_TICKS     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_ENABLE    = 3'd3;

    // Reset values.
    localparam logic [LEVEL_W-1:0]  START_LEVEL_RST    = 9'd255;
    localparam logic [BASE_W-1:0]   BASE_TICKS_RST     = 10'd10;
    localparam logic [THRESH_W-1:0] FADE_THRESHOLD_RST = 8'd2;
    localparam logic                FADE_ENABLE_RST    = 1'b1;

    // Fade bounds.
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 9'd511;
    localparam logic [LEVEL_W-1:0] FADE_TOP    = 9'd255;
    localparam logic [LEVEL_W-1:0] FADE_BOTTOM = 9'd1;

    typedef struct packed {
        logic                  pin_out;
        logic [LEVEL_W-1:0]    level_now;
        logic [SLOT_OUT_W-1:0] slot_now;
        logic                  frame_start;
    } t_result;

endpackage

@@ sv/bam_led_dimmer_with_fade.sv @@
`timescale 1ns / 1ps

// Output: a result appears in the cycle after its request is accepted while the output
// is free; one held in the skid register appears once the waiting output is taken.
// Throughput: one request per cycle; a skid register lets one more request in
// while the output register is stalled, so the input stalls only when both are full.
// Reset (synchronous, active low) loads the configuration defaults, sets the level
// to 255, rising, and clears the fade counter, slot index and slot tick counter.
module bam_led_dimmer_with_fade
    import bam_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_time_tick,
    input  logic                   i_fade_tick,

    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_pin_out,
    output logic [LEVEL_W-1:0]     o_level_now,
    output logic [SLOT_OUT_W-1:0]  o_slot_now,
    output logic                   o_frame_start
);

    localparam int SLOT_W = (LEVEL_BITS > 2) ? $clog2(LEVEL_BITS) : 1;
    localparam int TICK_W = BASE_W + LEVEL_BITS - 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(LEVEL_BITS - 1);

    // Configuration registers. The start level only matters at reset, where the
    // level is loaded from its fixed default, so a write to it has no effect.
    logic [BASE_W-1:0]   r_base_ticks;
    logic [THRESH_W-1:0] r_fade_threshold;
    logic                r_fade_enable;

    // Dimmer state.
    logic [LEVEL_W-1:0]    r_level,       n_level;
    logic                  r_falling,     n_falling;
    logic [FCOUNT_W-1:0]   r_fade_count,  n_fade_count;
    logic [LEVEL_BITS-1:0] r_frame_level, n_frame_level;
    logic [SLOT_W-1:0]     r_slot_index,  n_slot_index;
    logic [TICK_W-1:0]     r_slot_ticks,  n_slot_ticks;

    // Output register and skid register.
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    t_result n_result;

    logic in_accept;
    logic out_free;

    logic [LEVEL_W-1:0]            lvl_dec;
    logic                          fall_dec;
    logic [TICK_W-1:0]             slot_len;
    logic [TICK_W-1:0]             ticks_inc;
    logic [LEVEL_BITS+LEVEL_W-1:0] level_wide;
    logic [SLOT_W+SLOT_OUT_W-1:0]  slot_wide;
    logic                          frame_start;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_level       = r_level;
        n_falling     = r_falling;
        n_fade_count  = r_fade_count;
        n_frame_level = r_frame_level;
        n_slot_index  = r_slot_index;
        n_slot_ticks  = r_slot_ticks;
        frame_start   = 1'b0;
        lvl_dec       = r_level;
        fall_dec      = r_falling;

        // Fade step: a falling step that lands on the bottom turns around and
        // rises again in the same update.
        if (i_fade_tick && r_fade_enable) begin
            if (r_fade_count > r_fade_threshold) begin
                if (r_falling) begin
                    if (r_level != '0) begin
                        lvl_dec = r_level - 1'b1;
                    end
                    if (lvl_dec <= FADE_BOTTOM) begin
                        fall_dec = 1'b0;
                    end
                end
                n_level   = lvl_dec;
                n_falling = fall_dec;
                if (!fall_dec) begin
                    if (lvl_dec < LEVEL_MAX) begin
                        n_level = lvl_dec + 1'b1;
                    end
                    if (n_level >= FADE_TOP) begin
                        n_falling = 1'b1;
                    end
                end
                n_fade_count = FCOUNT_W'(1);
            end else begin
                n_fade_count = r_fade_count + 1'b1;
            end
        end

        slot_len   = TICK_W'(r_base_ticks) << r_slot_index;
        ticks_inc  = r_slot_ticks + 1'b1;
        level_wide = {{LEVEL_BITS{1'b0}}, n_level};

        if (i_time_tick) begin
            n_slot_ticks = ticks_inc;
            if (ticks_inc >= slot_len) begin
                n_slot_ticks = '0;
                if (r_slot_index >= SLOT_LAST) begin
                    n_slot_index  = '0;
                    n_frame_level = level_wide[LEVEL_BITS-1:0];
                    frame_start   = 1'b1;
                end else begin
                    n_slot_index = r_slot_index + 1'b1;
                end
            end
        end

        slot_wide            = {{SLOT_OUT_W{1'b0}}, n_slot_index};
        n_result.pin_out     = n_frame_level[n_slot_index];
        n_result.level_now   = n_level;
        n_result.slot_now    = slot_wide[SLOT_OUT_W-1:0];
        n_result.frame_start = frame_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_ticks     <= BASE_TICKS_RST;
            r_fade_threshold <= FADE_THRESHOLD_RST;
            r_fade_enable    <= FADE_ENABLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_START_LEVEL: begin
                end
                CFG_BASE_TICKS: begin
                    r_base_ticks <= i_cfg_data[BASE_W-1:0];
                end
                CFG_FADE_THRESHOLD: begin
                    r_fade_threshold <= i_cfg_data[THRESH_W-1:0];
                end
                CFG_FADE_ENABLE: begin
                    r_fade_enable <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level       <= START_LEVEL_RST;
            r_falling     <= 1'b0;
            r_fade_count  <= '0;
            r_frame_level <= LEVEL_BITS'({{LEVEL_BITS{1'b0}}, START_LEVEL_RST});
            r_slot_index  <= '0;
            r_slot_ticks  <= '0;
        end else if (in_accept) begin
            r_level       <= n_level;
            r_falling     <= n_falling;
            r_fade_count  <= n_fade_count;
            r_frame_level <= n_frame_level;
            r_slot_index  <= n_slot_index;
            r_slot_ticks  <= n_slot_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid  <= r_skid_valid || in_accept;
                r_skid_valid <= 1'b0;
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (!out_free && in_accept) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pin_out     = r_out.pin_out;
    assign o_level_now   = r_out.level_now;
    assign o_slot_now    = r_out.slot_now;
    assign o_frame_start = r_out.frame_start;

`ifndef NO_ASSERTIONS
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot_index <= SLOT_LAST)
        else $error("slot index beyond the last slot");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output is empty");

    a_fade_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !r_fade_enable |=> $stable(r_fade_count) && $stable(r_level))
        else $error("fade state moved while fading is disabled");

    a_frame_at_slot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_start |-> o_slot_now == '0)
        else $error("frame start reported away from the first slot");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import bam_pkg::*;

    localparam int                     CLK_HALF    = 10;
    localparam int                     IDLE_PCT    = 7;
    localparam int                     CYCLE_LIMIT = 100000;
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG  = 3'd7;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_START_LEVEL;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_time_tick = 1'b0;
    logic                   i_fade_tick = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic                   o_pin_out;
    logic [LEVEL_W-1:0]     o_level_now;
    logic [SLOT_OUT_W-1:0]  o_slot_now;
    logic                   o_frame_start;

    // Register copies as the dimmer should hold them.
    logic [LEVEL_W-1:0]  cf_start   = START_LEVEL_RST;
    logic [BASE_W-1:0]   cf_base    = BASE_TICKS_RST;
    logic [THRESH_W-1:0] cf_thresh  = FADE_THRESHOLD_RST;
    logic                cf_fade_en = FADE_ENABLE_RST;

    // Dimmer state as it should be after reset.
    logic [LEVEL_W-1:0]        pd_level       = START_LEVEL_RST;
    logic                      pd_falling     = 1'b0;
    logic [FCOUNT_W-1:0]       pd_fade_count  = '0;
    logic [LEVEL_BITS_DEF-1:0] pd_frame_level = START_LEVEL_RST[LEVEL_BITS_DEF-1:0];
    int unsigned               pd_slot        = 0;
    int unsigned               pd_slot_ticks  = 0;

    t_result expected_pin_states[$];
    t_result want;
    t_result got;

    bit steady = 1'b0;
    int errors = 0;
    int requests_sent = 0;
    int states_checked = 0;
    int frames_seen = 0;
    int level_low = 511;
    int level_high = 0;
    int cycles = 0;

    bam_led_dimmer_with_fade i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_time_tick   (i_time_tick),
        .i_fade_tick   (i_fade_tick),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pin_out     (o_pin_out),
        .o_level_now   (o_level_now),
        .o_slot_now    (o_slot_now),
        .o_frame_start (o_frame_start)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= i_rst_n && !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // Fade step first, then the slot timer, so a frame that starts in the same
    // request captures the level the fade just produced.
    function automatic t_result dimmer_next(input logic tick, input logic fade);
        t_result     r;
        int unsigned span;
        logic        starts;
        starts = 1'b0;
        if (fade && cf_fade_en) begin
            if (pd_fade_count > cf_thresh) begin
                if (pd_falling) begin
                    if (pd_level > 0) pd_level--;
                    if (pd_level <= FADE_BOTTOM) pd_falling = 1'b0;
                end
                if (!pd_falling) begin
                    if (pd_level < LEVEL_MAX) pd_level++;
                    if (pd_level >= FADE_TOP) pd_falling = 1'b1;
                end
                pd_fade_count = '0;
            end
            pd_fade_count++;
        end
        if (tick) begin
            span = 32'(cf_base) << pd_slot;
            pd_slot_ticks++;
            if (pd_slot_ticks >= span) begin
                pd_slot_ticks = 0;
                pd_slot++;
                if (pd_slot >= LEVEL_BITS_DEF) begin
                    pd_slot = 0;
                    pd_frame_level = pd_level[LEVEL_BITS_DEF-1:0];
                    starts = 1'b1;
                end
            end
        end
        r.pin_out     = pd_frame_level[pd_slot];
        r.level_now   = pd_level;
        r.slot_now    = SLOT_OUT_W'(pd_slot);
        r.frame_start = starts;
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_START_LEVEL:    cf_start   = i_cfg_data[LEVEL_W-1:0];
                    CFG_BASE_TICKS:     cf_base    = i_cfg_data[BASE_W-1:0];
                    CFG_FADE_THRESHOLD: cf_thresh  = i_cfg_data[THRESH_W-1:0];
                    CFG_FADE_ENABLE:    cf_fade_en = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{o_pin_out, o_level_now, o_slot_now, o_frame_start};
                if (expected_pin_states.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected pin state, expected none, actual %p", $time,
                             got);
                end else begin
                    want = expected_pin_states.pop_front();
                    check_field("pin_out", want.pin_out, got.pin_out);
                    check_field("level_now", want.level_now, got.level_now);
                    check_field("slot_now", want.slot_now, got.slot_now);
                    check_field("frame_start", want.frame_start, got.frame_start);
                    states_checked++;
                    if (got.frame_start) frames_seen++;
                    if (got.level_now < level_low) level_low = got.level_now;
                    if (got.level_now > level_high) level_high = got.level_now;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                expected_pin_states.push_back(dimmer_next(i_time_tick, i_fade_tick));
            end
        end
    end

    // Leaves valid high after acceptance so back-to-back requests need no extra edge.
    task automatic send_request(input logic tick, input logic fade);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_time_tick <= tick;
        i_fade_tick <= fade;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic send_mix(input int count, input int tick_pct, input int fade_pct);
        repeat (count) begin
            send_request($urandom_range(99) < tick_pct, $urandom_range(99) < fade_pct);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pin_states.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_request(1'b0, 1'b0);
        send_request(1'b1, 1'b0);
        send_request(1'b0, 1'b1);
        send_request(1'b1, 1'b1);
        drain_results();
        // An unused index must leave every register alone.
        write_reg(CFG_NO_REG, 10'h3FF);
        write_reg(CFG_BASE_TICKS, 10'd0);
        write_reg(CFG_START_LEVEL, 10'h3FF);
        // Zero base: one tick per slot, so every request moves on a slot while the
        // fade steps the level up to 256 and back down.
        repeat (16) send_request(1'b1, 1'b1);
    endtask

    task automatic test_fade_bounce();
        drain_results();
        write_reg(CFG_FADE_THRESHOLD, 10'd0);
        write_reg(CFG_BASE_TICKS, 10'd1);
        steady = 1'b1;
        send_mix(290, 50, 95);
        steady = 1'b0;
    endtask

    task automatic test_fade_disabled();
        drain_results();
        write_reg(CFG_FADE_ENABLE, 10'd0);
        write_reg(CFG_BASE_TICKS, 10'd2);
        send_mix(60, 70, 60);
        drain_results();
        write_reg(CFG_FADE_ENABLE, 10'd1);
    endtask

    task automatic test_counter_wrap();
        drain_results();
        write_reg(CFG_FADE_THRESHOLD, 10'd255);
        send_mix(270, 50, 100);
        drain_results();
        write_reg(CFG_FADE_THRESHOLD, 10'd1);
        send_mix(20, 50, 80);
    endtask

    // Every request ticks, so the slot tick counter advances on every request.
    task automatic test_long_slots();
        drain_results();
        write_reg(CFG_BASE_TICKS, 10'd50);
        send_mix(160, 100, 20);
    endtask

    task automatic test_random_configs();
        repeat (5) begin
            drain_results();
            write_reg(CFG_START_LEVEL, CFG_DATA_W'($urandom_range(1023)));
            write_reg(CFG_BASE_TICKS, CFG_DATA_W'($urandom_range(5)));
            write_reg(CFG_FADE_THRESHOLD, CFG_DATA_W'($urandom_range(4)));
            write_reg(CFG_FADE_ENABLE, CFG_DATA_W'($urandom_range(99) < 75));
            send_mix(30, $urandom_range(90, 20), $urandom_range(90, 10));
        end
        drain_results();
        write_reg(CFG_START_LEVEL, 10'd0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fade_bounce();
        test_fade_disabled();
        test_counter_wrap();
        test_long_slots();
        test_random_configs();
        drain_results();
        $display("Sent %0d requests and checked %0d pin states; %0d frames started.",
                 requests_sent, states_checked, frames_seen);
        $display("Level ranged %0d to %0d over slot bases 0 to 50 and thresholds 0 to 255.",
                 level_low, level_high);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
